>>> hdl/wgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants of the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } t_action;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic       en;       // update active bits this cycle
        logic       restart;  // reseed from position 0 instead of advancing
        logic [7:0] ch;       // folded text byte
        logic [7:0] sym;      // raw pattern byte for a write
    } t_cell_ctrl;

    typedef struct packed {
        logic overflow;
        logic matched;
    } t_result;

endpackage : wgm_pkg
`default_nettype wire

>>> hdl/wildcard_glob_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Streams text against a stored '*' / '?' pattern held in a row of cells.
// ----------------------------------------------------------------------------
// Input stream (s): one transfer per item. tdata[1:0] is the action (clear
// pattern, append pattern byte, text byte, end of text), tdata[9:2] the byte.
// Pattern spaces are dropped, text spaces skipped, text A..Z folded to lower.
// Output stream (m): one transfer per end-of-text item; tdata[0] = matched,
// tdata[1] = pattern overflow. Matching restarts after each end of text and
// after any pattern change.
// Throughput: one item per clock while o_s_tready is high. Every text byte
// other than a space updates all pattern cells in the same cycle; the star
// closure ripples through the cell row. An end-of-text result is registered
// into the output register, or into the skid register while that one is held.
// When the receiver stalls, up to two results are buffered; o_s_tready drops
// only once both entries are full.
// Reset (synchronous, active low) empties the pattern, clears overflow, and
// arms position 0; stored pattern bytes read only below the current length.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [1:0] action, [9:2] symbol, rest zero
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata    // [0] matched, [1] pattern_overflow, rest zero
);

    localparam int MAXP  = wgm_pkg::MAX_PATTERN;
    localparam int LEN_W = wgm_pkg::LEN_W;

    wgm_pkg::t_action    w_action;
    logic [7:0]          w_sym;
    logic                w_accept;
    logic                w_is_space;
    wgm_pkg::t_cell_ctrl w_ctrl;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    n_len;
    logic                r_ovf;
    logic                n_ovf;
    logic                r_tail;
    logic                w_full;
    logic [MAXP-1:0]     w_adv;
    logic [MAXP-1:0]     w_clo;
    logic [MAXP-1:0]     w_act;
    logic [MAXP-1:0]     w_valid;
    logic [MAXP-1:0]     w_n_valid;
    logic [MAXP-1:0]     w_wr;
    logic [MAXP:0]       w_act_all;
    logic                w_load;
    wgm_pkg::t_result    w_res;
    wgm_pkg::t_result    w_out;

    assign w_action   = wgm_pkg::t_action'(i_s_tdata[1:0]);
    assign w_sym      = i_s_tdata[9:2];
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_is_space = (w_sym == wgm_pkg::CH_SPACE);
    assign w_full     = (r_len == LEN_W'(MAXP));

    always_comb begin
        w_ctrl.restart = (w_action != wgm_pkg::ACT_TEXT);
        w_ctrl.en      = w_accept && !((w_action == wgm_pkg::ACT_TEXT) && w_is_space);
        w_ctrl.sym     = w_sym;
        if ((w_sym >= wgm_pkg::CH_UC_A) && (w_sym <= wgm_pkg::CH_UC_Z)) begin
            w_ctrl.ch = w_sym + wgm_pkg::CASE_OFS;
        end else begin
            w_ctrl.ch = w_sym;
        end
    end

    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        if (w_accept) begin
            case (w_action)
                wgm_pkg::ACT_CLEAR: begin
                    n_len = '0;
                    n_ovf = 1'b0;
                end
                wgm_pkg::ACT_APPEND: begin
                    if (!w_is_space) begin
                        if (w_full) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_len = r_len + LEN_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_tail <= 1'b0;
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
            if (w_ctrl.en) begin
                r_tail <= w_adv[MAXP-1] || w_clo[MAXP-1];
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAXP; gi++) begin : g_cell
            logic w_adv_in;
            logic w_clo_in;

            assign w_valid[gi]   = (LEN_W'(gi) < r_len);
            assign w_n_valid[gi] = (LEN_W'(gi) < n_len);
            assign w_wr[gi]      = w_accept && (w_action == wgm_pkg::ACT_APPEND) &&
                                   !w_is_space && (r_len == LEN_W'(gi));

            if (gi == 0) begin : g_head
                // restart seeds position 0
                assign w_adv_in = w_ctrl.restart;
                assign w_clo_in = 1'b0;
            end else begin : g_body
                assign w_adv_in = w_adv[gi-1];
                assign w_clo_in = w_clo[gi-1];
            end

            wgm_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_head    ((gi == 0) ? 1'b1 : 1'b0),
                .i_wr      (w_wr[gi]),
                .i_valid   (w_valid[gi]),
                .i_n_valid (w_n_valid[gi]),
                .i_adv     (w_adv_in),
                .i_clo     (w_clo_in),
                .o_adv     (w_adv[gi]),
                .o_clo     (w_clo[gi]),
                .o_act     (w_act[gi])
            );
        end
    endgenerate

    assign w_act_all    = {r_tail, w_act};
    assign w_load       = w_accept && (w_action == wgm_pkg::ACT_END);
    assign w_res.matched  = w_act_all[r_len] && !r_ovf;
    assign w_res.overflow = r_ovf;

    wgm_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_data     (w_res),
        .o_ready    (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_data     (w_out)
    );

    assign o_m_tdata = {6'd0, w_out.overflow, w_out.matched};

endmodule : wildcard_glob_matcher
`default_nettype wire

>>> hdl/wgm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: holds a pattern byte and its active bit, passes
// advance and empty-match (star) closure to the next position.
// ----------------------------------------------------------------------------
module wgm_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire wgm_pkg::t_cell_ctrl i_ctrl,
    input  wire                      i_head,     // reset value of the active bit
    input  wire                      i_wr,       // store i_ctrl.sym here
    input  wire                      i_valid,    // position below current length
    input  wire                      i_n_valid,  // position below next length
    input  wire                      i_adv,      // active from previous position
    input  wire                      i_clo,      // closure from previous position
    output logic                     o_adv,
    output logic                     o_clo,
    output logic                     o_act
);

    logic [7:0] r_sym;
    logic [7:0] n_sym;
    logic       r_act;
    logic       n_act;
    logic       w_star;
    logic       w_n_star;
    logic       w_raw;

    always_comb begin
        n_sym    = i_wr ? i_ctrl.sym : r_sym;
        w_star   = i_valid && (r_sym == wgm_pkg::CH_STAR);
        w_n_star = i_n_valid && (n_sym == wgm_pkg::CH_STAR);
        o_adv    = !i_ctrl.restart && r_act && i_valid && !w_star &&
                   ((r_sym == wgm_pkg::CH_QUERY) || (r_sym == i_ctrl.ch));
        // a star keeps its own position alive
        w_raw    = i_adv || (!i_ctrl.restart && r_act && w_star);
        n_act    = w_raw || i_clo;
        o_clo    = n_act && w_n_star;
        o_act    = r_act;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_sym <= i_ctrl.sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= i_head;
        end else if (i_ctrl.en) begin
            r_act <= n_act;
        end
    end

endmodule : wgm_cell
`default_nettype wire

>>> hdl/wgm_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_out_buf
// Two-entry result buffer: output register plus skid register, so the
// input side keeps moving while a result waits.
// ----------------------------------------------------------------------------
module wgm_out_buf (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  wire wgm_pkg::t_result i_data,
    output logic                  o_ready,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output wgm_pkg::t_result      o_data
);

    logic             r_m_valid;
    logic             r_s_valid;
    wgm_pkg::t_result r_m_data;
    wgm_pkg::t_result r_s_data;
    logic             w_take;

    assign o_ready    = !r_s_valid;
    assign o_m_tvalid = r_m_valid;
    assign o_data     = r_m_data;
    assign w_take     = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (w_take) begin
            if (r_s_valid) begin
                r_m_valid <= 1'b1;
                r_s_valid <= i_load;
            end else begin
                r_m_valid <= i_load;
            end
        end else if (i_load) begin
            r_s_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_s_valid) begin
                r_m_data <= r_s_data;
                r_s_data <= i_data;
            end else begin
                r_m_data <= i_data;
            end
        end else if (i_load) begin
            r_s_data <= i_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_m_valid)
        else $error("skid entry held without output entry");

    a_no_load_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load && r_s_valid))
        else $error("result loaded into full buffer");

    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_tready) |=> (r_m_valid && $stable(r_m_data)))
        else $error("stalled result lost or changed");

endmodule : wgm_out_buf
`default_nettype wire
